[rtl/qrpy_pkg.sv]
// Shared types, constants and table functions for the quaternion to roll/pitch/yaw unit.
package qrpy_pkg;

   localparam int QUAT_W      = 16;
   localparam int OUT_W       = 16;
   localparam int ANGLE_BITS  = 16;
   localparam int ANG_W       = 32;
   localparam int VEC_W       = 40;
   localparam int ROT_W       = 34;
   localparam int CS_W        = 32;
   localparam int TAB_LEN     = 24;
   localparam int INV_GAIN_Q30 = 652032874;
   localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;
   localparam logic signed [VEC_W-1:0] ONE_Q28 = 40'sd268435456;

   typedef struct packed {
      logic signed [QUAT_W-1:0] w;
      logic signed [QUAT_W-1:0] x;
      logic signed [QUAT_W-1:0] y;
      logic signed [QUAT_W-1:0] z;
   } quat_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic [ANG_W-1:0]        ang;
      logic                    zero;
   } vec_type;

   typedef struct packed {
      logic signed [ROT_W-1:0] x;
      logic signed [ROT_W-1:0] y;
      logic signed [ROT_W-1:0] a;
   } rot_type;

   // atan(2^-i) in turn units, 2^32 per turn
   function automatic logic [ANG_W-1:0] atan_turn(input int step);
      logic [ANG_W-1:0] v;
      case (step)
         0:  v = 32'd536870912;
         1:  v = 32'd316933406;
         2:  v = 32'd167458907;
         3:  v = 32'd85004756;
         4:  v = 32'd42667331;
         5:  v = 32'd21354465;
         6:  v = 32'd10679838;
         7:  v = 32'd5340245;
         8:  v = 32'd2670163;
         9:  v = 32'd1335087;
         10: v = 32'd667544;
         11: v = 32'd333772;
         12: v = 32'd166886;
         13: v = 32'd83443;
         14: v = 32'd41722;
         15: v = 32'd20861;
         16: v = 32'd10430;
         17: v = 32'd5215;
         18: v = 32'd2608;
         19: v = 32'd1304;
         20: v = 32'd652;
         21: v = 32'd326;
         22: v = 32'd163;
         23: v = 32'd81;
         default: v = '0;
      endcase
      return v;
   endfunction

   // round a turn angle to ANGLE_BITS, keep the low output bits
   function automatic logic [OUT_W-1:0] to_output(input logic [ANG_W-1:0] a);
      logic [ANG_W-1:0] sum;
      logic [ANG_W-1:0] shifted;
      sum     = a + (ANG_W'(1) << (31 - ANGLE_BITS));
      shifted = sum >> (ANG_W - ANGLE_BITS);
      return shifted[OUT_W-1:0];
   endfunction

endpackage

[rtl/qrpy_if.sv]
// Valid/ready channel interfaces for quaternion requests and angle responses.
interface qrpy_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] quat_w;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;
   modport source (output valid, output quat_w, output quat_x, output quat_y, output quat_z,
                   input ready);
   modport sink (input valid, input quat_w, input quat_x, input quat_y, input quat_z,
                 output ready);
endinterface

interface qrpy_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] roll_angle;
   logic signed [15:0] pitch_angle;
   logic signed [15:0] yaw_angle;
   modport source (output valid, output roll_angle, output pitch_angle, output yaw_angle,
                   input ready);
   modport sink (input valid, input roll_angle, input pitch_angle, input yaw_angle,
                 output ready);
endinterface

[rtl/qrpy_cordic_vec.sv]
// Pipelined CORDIC vectoring: atan2 and scaled length, one micro-rotation per stage.
module qrpy_cordic_vec
   import qrpy_pkg::*;
#(
   parameter int STEPS  = 16,
   parameter int SIDE_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [VEC_W-1:0] in_x,
   input  logic signed [VEC_W-1:0] in_y,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   output logic signed [VEC_W-1:0] out_len,
   output logic [ANG_W-1:0]        out_ang,
   output logic [SIDE_W-1:0]       out_side
);

   vec_type           v_ff    [STEPS+1];
   logic              val_ff  [STEPS+1];
   logic [SIDE_W-1:0] side_ff [STEPS+1];
   vec_type           pre_in;

   // fold the left half-plane over and note the zero vector
   always_comb begin
      pre_in.zero = (in_x == '0) && (in_y == '0);
      if (in_x < 0) begin
         pre_in.x   = -in_x;
         pre_in.y   = -in_y;
         pre_in.ang = HALF_TURN;
      end else begin
         pre_in.x   = in_x;
         pre_in.y   = in_y;
         pre_in.ang = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff[0] <= 1'b0;
      end else if (en) begin
         val_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff[0]    <= pre_in;
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic [ANG_W-1:0] ATAN_C = atan_turn(i);
      logic signed [VEC_W-1:0] xi;
      logic signed [VEC_W-1:0] yi;
      logic signed [VEC_W-1:0] dx;
      logic signed [VEC_W-1:0] dy;
      vec_type                 v_in;

      always_comb begin
         xi   = v_ff[i].x;
         yi   = v_ff[i].y;
         dx   = yi >>> i;
         dy   = xi >>> i;
         v_in = v_ff[i];
         if (yi > 0) begin
            v_in.x   = xi + dx;
            v_in.y   = yi - dy;
            v_in.ang = v_ff[i].ang + ATAN_C;
         end else begin
            v_in.x   = xi - dx;
            v_in.y   = yi + dy;
            v_in.ang = v_ff[i].ang - ATAN_C;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[i+1] <= 1'b0;
         end else if (en) begin
            val_ff[i+1] <= val_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[i+1]    <= v_in;
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = val_ff[STEPS];
   assign out_len   = v_ff[STEPS].x;
   assign out_ang   = v_ff[STEPS].zero ? '0 : v_ff[STEPS].ang;
   assign out_side  = side_ff[STEPS];

endmodule

[rtl/qrpy_cordic_rot.sv]
// Pipelined CORDIC rotation: cos and sin in Q30 of an angle within a quarter turn.
module qrpy_cordic_rot
   import qrpy_pkg::*;
#(
   parameter int STEPS  = 16,
   parameter int SIDE_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [ANG_W-1:0] in_angle,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   output logic signed [CS_W-1:0]  out_cos,
   output logic signed [CS_W-1:0]  out_sin,
   output logic [SIDE_W-1:0]       out_side
);

   rot_type           r_ff    [STEPS+1];
   logic              val_ff  [STEPS+1];
   logic [SIDE_W-1:0] side_ff [STEPS+1];
   rot_type           pre_in;

   // start on the x axis, prescaled by the inverse gain
   always_comb begin
      pre_in.x = ROT_W'(INV_GAIN_Q30);
      pre_in.y = '0;
      pre_in.a = ROT_W'(in_angle);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff[0] <= 1'b0;
      end else if (en) begin
         val_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]    <= pre_in;
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [ROT_W-1:0] ATAN_S = ROT_W'(atan_turn(i));
      logic signed [ROT_W-1:0] xi;
      logic signed [ROT_W-1:0] yi;
      logic signed [ROT_W-1:0] ai;
      logic signed [ROT_W-1:0] dx;
      logic signed [ROT_W-1:0] dy;
      rot_type                 r_in;

      always_comb begin
         xi = r_ff[i].x;
         yi = r_ff[i].y;
         ai = r_ff[i].a;
         dx = yi >>> i;
         dy = xi >>> i;
         if (ai >= 0) begin
            r_in.x = xi - dx;
            r_in.y = yi + dy;
            r_in.a = ai - ATAN_S;
         end else begin
            r_in.x = xi + dx;
            r_in.y = yi - dy;
            r_in.a = ai + ATAN_S;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[i+1] <= 1'b0;
         end else if (en) begin
            val_ff[i+1] <= val_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[i+1]    <= r_in;
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = val_ff[STEPS];
   assign out_cos   = CS_W'(r_ff[STEPS].x);
   assign out_sin   = CS_W'(r_ff[STEPS].y);
   assign out_side  = side_ff[STEPS];

endmodule

[rtl/quat_to_roll_pitch_yaw_unit.sv]
// Quaternion to Z-Y-X roll/pitch/yaw converter, top level.
// Usage:
//   req_ch carries one unit quaternion (w,x,y,z, signed Q1.14) per transaction.
//   rsp_ch returns roll, pitch and yaw as 16-bit binary angles (32768 = pi),
//   one response per request, in request order.
// Datapath: four CORDIC chains in series from request to response: yaw
//   atan2, pitch atan2 (with the yaw sin/cos alongside), pitch sin/cos, roll
//   atan2, plus multiply stages.
// Throughput: one transaction per cycle while not stalled; every stage is one register deep.
// Stall: the whole pipe advances only when the response register is empty or
//   taken, so req_ch.ready drops while a response waits unaccepted; nothing is
//   lost or repeated.
// Reset: synchronous, clears all valid bits; no clearing sweep, ready again
//   as soon as reset is released.
module quat_to_roll_pitch_yaw_unit
   import qrpy_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic     clock,
   input  logic     reset,
   qrpy_req_if.sink   req_ch,
   qrpy_rsp_if.source rsp_ch
);

   localparam int HALF_W = VEC_W / 2;
   localparam int PROD_W = HALF_W + 30;
   localparam int QP_W   = QUAT_W + CS_W;
   localparam int GP_W   = 2 * CS_W;

   logic en;

   // stage A: input capture
   quat_type q_a_ff;
   logic     val_a_ff;

   // stage B: rotated x axis
   logic signed [VEC_W-1:0] rx_b_in, ry_b_in, rz_b_in;
   logic signed [VEC_W-1:0] rx_b_ff, ry_b_ff, rz_b_ff;
   logic signed [2*QUAT_W-1:0] p_yy, p_zz, p_xy, p_wz, p_xz, p_wy;
   quat_type q_b_ff;
   logic     val_b_ff;

   // yaw vectoring
   logic                    yvec_valid;
   logic signed [VEC_W-1:0] yaw_len;
   logic [ANG_W-1:0]        yaw_ang;
   logic [QP_W+VEC_W-QUAT_W-CS_W+4*QUAT_W-1:0] yvec_side;
   quat_type                q_yv;
   logic signed [VEC_W-1:0] rz_yv;

   // stage C/D: length scaled by 1/K
   logic [PROD_W-1:0]       plo_c_ff, phi_c_ff;
   logic signed [VEC_W-1:0] rz_c_ff;
   quat_type                q_c_ff;
   logic [ANG_W-1:0]        yaw_c_ff;
   logic                    val_c_ff;
   logic [PROD_W+HALF_W-1:0] full_d;
   logic signed [VEC_W-1:0] r_d_ff, nrz_d_ff;
   quat_type                q_d_ff;
   logic [ANG_W-1:0]        yaw_d_ff;
   logic                    val_d_ff;

   // pitch vectoring beside yaw sin/cos
   logic                    pvec_valid;
   logic signed [VEC_W-1:0] pitch_len;
   logic [ANG_W-1:0]        pitch_ang;
   logic [ANG_W-1:0]        yaw_pv;
   logic                    yrot_valid;
   logic signed [CS_W-1:0]  yr_cos, yr_sin;
   logic [4*QUAT_W-1:0]     yrot_side;

   // pitch sin/cos
   logic [4*QUAT_W+4*CS_W-1:0] prot_in_side, prot_side;
   logic                    prot_valid;
   logic signed [CS_W-1:0]  pr_cos, pr_sin;
   quat_type                q_pr;
   logic signed [CS_W-1:0]  cz_pr, sz_pr;
   logic [ANG_W-1:0]        yaw_pr, pitch_pr;

   // stages E..H: take yaw then pitch out of q
   logic signed [QP_W-1:0]  pe_ff [8];
   logic signed [CS_W-1:0]  cy_e_ff, sy_e_ff;
   logic [ANG_W-1:0]        yaw_e_ff, pitch_e_ff;
   logic                    val_e_ff;
   logic signed [CS_W-1:0]  w1_f_ff, x1_f_ff, y1_f_ff, z1_f_ff;
   logic signed [CS_W-1:0]  cy_f_ff, sy_f_ff;
   logic [ANG_W-1:0]        yaw_f_ff, pitch_f_ff;
   logic                    val_f_ff;
   logic signed [GP_W-1:0]  pg_ff [4];
   logic [ANG_W-1:0]        yaw_g_ff, pitch_g_ff;
   logic                    val_g_ff;
   logic signed [VEC_W-1:0] w2_h_ff, x2_h_ff;
   logic [ANG_W-1:0]        yaw_h_ff, pitch_h_ff;
   logic                    val_h_ff;

   // roll vectoring and output
   logic                    rvec_valid;
   logic signed [VEC_W-1:0] roll_len;
   logic [ANG_W-1:0]        half_roll;
   logic [2*ANG_W-1:0]      rvec_side;
   logic                    out_v_ff;
   logic [OUT_W-1:0]        roll_ff, pitch_ff, yaw_ff;

   assign en           = !out_v_ff || rsp_ch.ready;
   // no transaction is taken while reset is held
   assign req_ch.ready = en && !reset;

   // ---- stage A
   always_ff @(posedge clock) begin
      if (reset) begin
         val_a_ff <= 1'b0;
      end else if (en) begin
         val_a_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_a_ff.w <= req_ch.quat_w;
         q_a_ff.x <= req_ch.quat_x;
         q_a_ff.y <= req_ch.quat_y;
         q_a_ff.z <= req_ch.quat_z;
      end
   end

   // ---- stage B: first column of the rotation matrix, Q28
   always_comb begin
      p_yy    = q_a_ff.y * q_a_ff.y;
      p_zz    = q_a_ff.z * q_a_ff.z;
      p_xy    = q_a_ff.x * q_a_ff.y;
      p_wz    = q_a_ff.w * q_a_ff.z;
      p_xz    = q_a_ff.x * q_a_ff.z;
      p_wy    = q_a_ff.w * q_a_ff.y;
      rx_b_in = ONE_Q28 - ((VEC_W'(p_yy) + VEC_W'(p_zz)) <<< 1);
      ry_b_in = (VEC_W'(p_xy) + VEC_W'(p_wz)) <<< 1;
      rz_b_in = (VEC_W'(p_xz) - VEC_W'(p_wy)) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_b_ff <= 1'b0;
      end else if (en) begin
         val_b_ff <= val_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rx_b_ff <= rx_b_in;
         ry_b_ff <= ry_b_in;
         rz_b_ff <= rz_b_in;
         q_b_ff  <= q_a_ff;
      end
   end

   // ---- yaw = atan2(ry, rx)
   qrpy_cordic_vec #(
      .STEPS  (CORDIC_STEPS),
      .SIDE_W (4*QUAT_W + VEC_W)
   ) u_yaw_vec (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (val_b_ff),
      .in_x      (rx_b_ff),
      .in_y      (ry_b_ff),
      .in_side   ({q_b_ff, rz_b_ff}),
      .out_valid (yvec_valid),
      .out_len   (yaw_len),
      .out_ang   (yaw_ang),
      .out_side  (yvec_side)
   );

   assign {q_yv, rz_yv} = yvec_side;

   // ---- stage C: length * 1/K as two partial products
   always_ff @(posedge clock) begin
      if (reset) begin
         val_c_ff <= 1'b0;
      end else if (en) begin
         val_c_ff <= yvec_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         plo_c_ff <= PROD_W'(yaw_len[HALF_W-1:0]) * PROD_W'(INV_GAIN_Q30);
         phi_c_ff <= PROD_W'(yaw_len[VEC_W-1:HALF_W]) * PROD_W'(INV_GAIN_Q30);
         rz_c_ff  <= rz_yv;
         q_c_ff   <= q_yv;
         yaw_c_ff <= yaw_ang;
      end
   end

   // ---- stage D: combine, drop 30 fraction bits
   assign full_d = {phi_c_ff, {HALF_W{1'b0}}} + (PROD_W + HALF_W)'(plo_c_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         val_d_ff <= 1'b0;
      end else if (en) begin
         val_d_ff <= val_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_d_ff   <= $signed(full_d[VEC_W+29:30]);
         nrz_d_ff <= -rz_c_ff;
         q_d_ff   <= q_c_ff;
         yaw_d_ff <= yaw_c_ff;
      end
   end

   // ---- pitch = atan2(-rz, |rxy|); yaw half-angle sin/cos in parallel
   qrpy_cordic_vec #(
      .STEPS  (CORDIC_STEPS),
      .SIDE_W (ANG_W)
   ) u_pitch_vec (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (val_d_ff),
      .in_x      (r_d_ff),
      .in_y      (nrz_d_ff),
      .in_side   (yaw_d_ff),
      .out_valid (pvec_valid),
      .out_len   (pitch_len),
      .out_ang   (pitch_ang),
      .out_side  (yaw_pv)
   );

   qrpy_cordic_rot #(
      .STEPS  (CORDIC_STEPS),
      .SIDE_W (4*QUAT_W)
   ) u_yaw_rot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (val_d_ff),
      .in_angle  ($signed(yaw_d_ff) >>> 1),
      .in_side   (q_d_ff),
      .out_valid (yrot_valid),
      .out_cos   (yr_cos),
      .out_sin   (yr_sin),
      .out_side  (yrot_side)
   );

   assign prot_in_side = {yrot_side, yr_cos, -yr_sin, yaw_pv, pitch_ang};

   qrpy_cordic_rot #(
      .STEPS  (CORDIC_STEPS),
      .SIDE_W (4*QUAT_W + 4*CS_W)
   ) u_pitch_rot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pvec_valid),
      .in_angle  ($signed(pitch_ang) >>> 1),
      .in_side   (prot_in_side),
      .out_valid (prot_valid),
      .out_cos   (pr_cos),
      .out_sin   (pr_sin),
      .out_side  (prot_side)
   );

   assign {q_pr, cz_pr, sz_pr, yaw_pr, pitch_pr} = prot_side;

   // ---- stage E: Rot_z(-yaw) * q products
   always_ff @(posedge clock) begin
      if (reset) begin
         val_e_ff <= 1'b0;
      end else if (en) begin
         val_e_ff <= prot_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pe_ff[0]   <= cz_pr * q_pr.w;
         pe_ff[1]   <= sz_pr * q_pr.z;
         pe_ff[2]   <= cz_pr * q_pr.x;
         pe_ff[3]   <= sz_pr * q_pr.y;
         pe_ff[4]   <= cz_pr * q_pr.y;
         pe_ff[5]   <= sz_pr * q_pr.x;
         pe_ff[6]   <= cz_pr * q_pr.z;
         pe_ff[7]   <= sz_pr * q_pr.w;
         cy_e_ff    <= pr_cos;
         sy_e_ff    <= -pr_sin;
         yaw_e_ff   <= yaw_pr;
         pitch_e_ff <= pitch_pr;
      end
   end

   // ---- stage F: Q44 sums down to Q28
   always_ff @(posedge clock) begin
      if (reset) begin
         val_f_ff <= 1'b0;
      end else if (en) begin
         val_f_ff <= val_e_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w1_f_ff    <= CS_W'((pe_ff[0] - pe_ff[1]) >>> 16);
         x1_f_ff    <= CS_W'((pe_ff[2] - pe_ff[3]) >>> 16);
         y1_f_ff    <= CS_W'((pe_ff[4] + pe_ff[5]) >>> 16);
         z1_f_ff    <= CS_W'((pe_ff[6] + pe_ff[7]) >>> 16);
         cy_f_ff    <= cy_e_ff;
         sy_f_ff    <= sy_e_ff;
         yaw_f_ff   <= yaw_e_ff;
         pitch_f_ff <= pitch_e_ff;
      end
   end

   // ---- stage G: Rot_y(-pitch) products, only w and x are needed
   always_ff @(posedge clock) begin
      if (reset) begin
         val_g_ff <= 1'b0;
      end else if (en) begin
         val_g_ff <= val_f_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pg_ff[0]   <= cy_f_ff * w1_f_ff;
         pg_ff[1]   <= sy_f_ff * y1_f_ff;
         pg_ff[2]   <= cy_f_ff * x1_f_ff;
         pg_ff[3]   <= sy_f_ff * z1_f_ff;
         yaw_g_ff   <= yaw_f_ff;
         pitch_g_ff <= pitch_f_ff;
      end
   end

   // ---- stage H: Q58 down to Q28
   always_ff @(posedge clock) begin
      if (reset) begin
         val_h_ff <= 1'b0;
      end else if (en) begin
         val_h_ff <= val_g_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w2_h_ff    <= VEC_W'((pg_ff[0] - pg_ff[1]) >>> 30);
         x2_h_ff    <= VEC_W'((pg_ff[2] + pg_ff[3]) >>> 30);
         yaw_h_ff   <= yaw_g_ff;
         pitch_h_ff <= pitch_g_ff;
      end
   end

   // ---- half roll = atan2(x', w')
   qrpy_cordic_vec #(
      .STEPS  (CORDIC_STEPS),
      .SIDE_W (2*ANG_W)
   ) u_roll_vec (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (val_h_ff),
      .in_x      (w2_h_ff),
      .in_y      (x2_h_ff),
      .in_side   ({yaw_h_ff, pitch_h_ff}),
      .out_valid (rvec_valid),
      .out_len   (roll_len),
      .out_ang   (half_roll),
      .out_side  (rvec_side)
   );

   // ---- response register; doubling wraps roll into one turn
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= rvec_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         roll_ff  <= to_output({half_roll[ANG_W-2:0], 1'b0});
         yaw_ff   <= to_output(rvec_side[2*ANG_W-1:ANG_W]);
         pitch_ff <= to_output(rvec_side[ANG_W-1:0]);
      end
   end

   assign rsp_ch.valid       = out_v_ff;
   assign rsp_ch.roll_angle  = $signed(roll_ff);
   assign rsp_ch.pitch_angle = $signed(pitch_ff);
   assign rsp_ch.yaw_angle   = $signed(yaw_ff);

`ifndef ASSERT_OFF
   // yaw sin/cos and pitch atan2 run side by side and must stay in step
   a_side_by_side: assert property (@(posedge clock) disable iff (reset)
      yrot_valid == pvec_valid)
      else $error("yaw rotation and pitch vectoring out of step");

   // vectoring lengths start in the right half-plane and never shrink below zero
   a_yaw_len: assert property (@(posedge clock) disable iff (reset)
      yvec_valid |-> !yaw_len[VEC_W-1])
      else $error("negative yaw vector length");

   a_pitch_len: assert property (@(posedge clock) disable iff (reset)
      pvec_valid |-> !pitch_len[VEC_W-1])
      else $error("negative pitch vector length");

   a_roll_len: assert property (@(posedge clock) disable iff (reset)
      rvec_valid |-> !roll_len[VEC_W-1])
      else $error("negative roll vector length");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid right after reset");
`endif

endmodule
